// ----- rtl/ssti_pkg.sv -----
`default_nettype none
package ssti_pkg;
  localparam int QueueDepth = 16;
  localparam int TimeW = 40;
  localparam int LatW  = 38;
  localparam int LonW  = 39;
  localparam int MmW   = 32;
  localparam int RecW  = TimeW + LatW + LonW + 4 * MmW;
  localparam int MagW  = 41;
  localparam int ProdW = MagW + TimeW;
  localparam logic [TimeW-1:0] MaxGapReset = 40'd200000;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_SYNC = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_LATER   = 2'd2;
  localparam logic [1:0] ST_GAP     = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]       t;
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic signed [MmW-1:0]  alt;
    logic signed [MmW-1:0]  east;
    logic signed [MmW-1:0]  north;
    logic signed [MmW-1:0]  up;
  } rec_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] num;
    logic [TimeW-1:0] den;
  } div_req_t;
endpackage
`default_nettype wire

// ----- rtl/ssti_ram.sv -----
`default_nettype none
module ssti_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/ssti_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle
module ssti_div
  import ssti_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_req_t         req,
  output logic                  busy,
  output logic [ProdW-1:0]      quo
);
  localparam int CntW = $clog2(ProdW + 1);
  logic [ProdW-1:0] num_r, quo_r;
  logic [TimeW:0]   rem_r;
  logic [TimeW-1:0] den_r;
  logic [CntW-1:0]  cnt_r;
  logic [TimeW:0]   sh;
  logic             ge;

  assign sh = {rem_r[TimeW-1:0], num_r[ProdW-1]};
  assign ge = sh >= {1'b0, den_r};
  assign busy = cnt_r != '0;
  assign quo = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= CntW'(ProdW);
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
      num_r <= num_r << 1;
      rem_r <= ge ? sh - {1'b0, den_r} : sh;
      quo_r <= {quo_r[ProdW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sensor_sample_time_interpolator_unit.sv -----
// Push: accepted with no result. Request: with fewer than two samples it goes
// straight to the result, else each queue step passes the states RDA, RDB, CHK
// (each discarded sample adds a step); an ok request then runs, per field, a
// serial multiply and a serial divide. One item at a time.
// Synchronous reset (rst_n low) empties the queue and sets max_gap to 200000;
// the sample memory keeps its contents and needs no clearing.
`default_nettype none
module sensor_sample_time_interpolator_unit
  import ssti_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_opcode,
  input  wire logic [TimeW-1:0]        in_stamp,
  input  wire logic signed [LatW-1:0]  in_lat_in,
  input  wire logic signed [LonW-1:0]  in_lon_in,
  input  wire logic signed [MmW-1:0]   in_alt_in,
  input  wire logic signed [MmW-1:0]   in_east_in,
  input  wire logic signed [MmW-1:0]   in_north_in,
  input  wire logic signed [MmW-1:0]   in_up_in,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [TimeW-1:0]        cfg_max_gap,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic [TimeW-1:0]             out_stamp_out,
  output logic signed [LatW-1:0]       out_lat_out,
  output logic signed [LonW-1:0]       out_lon_out,
  output logic signed [MmW-1:0]        out_alt_out,
  output logic signed [MmW-1:0]        out_east_out,
  output logic signed [MmW-1:0]        out_north_out,
  output logic signed [MmW-1:0]        out_up_out
);
  localparam int AW = $clog2(QDepth);
  localparam int FW = $clog2(QDepth + 1);
  localparam int MulCntW = $clog2(TimeW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_WAIT = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DWT  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       st_r;
  logic [AW-1:0]    head_r;
  logic [FW-1:0]    fill_r;
  logic [TimeW-1:0] gap_r, t_r;
  rec_t             a_r, b_r, rd;
  logic [2:0]       fld_r;
  logic             neg_r;
  logic signed [LonW-1:0] res_r [6];
  logic [1:0]       stat_r;

  // sample memory: one RAM, packed record
  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wrec;
  logic [RecW-1:0] rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [FW-1:0] k);
    logic [FW:0] s;
    s = (FW+1)'(h) + (FW+1)'(k);
    if (s >= (FW+1)'(QDepth)) s = s - (FW+1)'(QDepth);
    return s[AW-1:0];
  endfunction

  assign in_ready  = st_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign we = in_valid && in_ready && in_opcode == OP_PUSH;
  assign waddr = (fill_r == FW'(QDepth)) ? head_r : slot(head_r, fill_r);
  assign wrec = '{in_stamp, in_lat_in, in_lon_in, in_alt_in, in_east_in,
                  in_north_in, in_up_in};
  assign raddr = (st_r == S_RDA) ? head_r : slot(head_r, FW'(1));
  assign rd = rdata;

  ssti_ram #(.Width(RecW), .Depth(QDepth)) u_ram (
    .clk, .we, .waddr, .wdata(wrec), .raddr, .rdata
  );

  // field selection for the divider
  logic signed [LonW:0] fa, fb, diff;
  always_comb begin
    case (fld_r)
      3'd0: begin fa = (LonW+1)'(a_r.lat);  fb = (LonW+1)'(b_r.lat);  end
      3'd1: begin fa = (LonW+1)'(a_r.lon);  fb = (LonW+1)'(b_r.lon);  end
      3'd2: begin fa = (LonW+1)'(a_r.alt);  fb = (LonW+1)'(b_r.alt);  end
      3'd3: begin fa = (LonW+1)'(a_r.east); fb = (LonW+1)'(b_r.east); end
      3'd4: begin fa = (LonW+1)'(a_r.north);fb = (LonW+1)'(b_r.north);end
      default: begin fa = (LonW+1)'(a_r.up); fb = (LonW+1)'(b_r.up); end
    endcase
    diff = fb - fa;
  end

  // magnitude times w, shift-add one bit of w per cycle, then the divider
  logic [MagW-1:0]    mag;
  logic [TimeW-1:0]   w, d;
  logic [ProdW-1:0]   prod_r, mcand_r;
  logic [TimeW-1:0]   mplr_r;
  logic [MulCntW-1:0] mcnt_r;
  div_req_t           dreq;
  logic               dbusy;
  logic [ProdW-1:0]   quo;
  assign mag = diff[LonW] ? MagW'(-diff) : MagW'(diff);
  assign w = t_r - a_r.t;
  assign d = b_r.t - a_r.t;
  assign dreq = '{start: st_r == S_DIV, num: prod_r, den: d};

  ssti_div u_div (.clk, .rst_n, .req(dreq), .busy(dbusy), .quo);

  logic signed [LonW:0] res_v;
  assign res_v = neg_r ? fa - (LonW+1)'(quo) : fa + (LonW+1)'(quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      head_r <= '0;
      fill_r <= '0;
      gap_r <= MaxGapReset;
    end else begin
      if (cfg_valid) gap_r <= cfg_max_gap;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          if (in_opcode == OP_PUSH) begin
            if (fill_r == FW'(QDepth)) head_r <= slot(head_r, FW'(1));
            else fill_r <= fill_r + FW'(1);
          end else begin
            t_r <= in_stamp;
            if (fill_r < FW'(2)) begin
              stat_r <= ST_FEW; st_r <= S_OUT;
            end else st_r <= S_RDA;
          end
        end
        S_RDA: st_r <= S_RDB;
        S_RDB: begin a_r <= rd; st_r <= S_CHK; end
        S_CHK: begin
          b_r <= rd;
          fld_r <= '0;
          if (a_r.t > t_r) begin
            stat_r <= ST_LATER; st_r <= S_OUT;
          end else if (rd.t < t_r) begin
            head_r <= slot(head_r, FW'(1));
            fill_r <= fill_r - FW'(1);
            if (fill_r == FW'(2)) begin
              stat_r <= ST_FEW; st_r <= S_OUT;
            end else st_r <= S_RDA;
          end else if (t_r - a_r.t > gap_r || rd.t - t_r > gap_r) begin
            head_r <= slot(head_r, FW'(1));
            fill_r <= fill_r - FW'(1);
            stat_r <= ST_GAP; st_r <= S_OUT;
          end else begin
            stat_r <= ST_OK; st_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          // set up the multiply for the current field
          prod_r <= '0;
          mcand_r <= ProdW'(mag);
          mplr_r <= w;
          mcnt_r <= MulCntW'(TimeW);
          neg_r <= diff[LonW];
          st_r <= S_MUL;
        end
        S_MUL: begin
          if (mplr_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r <= mcand_r << 1;
          mplr_r <= mplr_r >> 1;
          mcnt_r <= mcnt_r - MulCntW'(1);
          if (mcnt_r == MulCntW'(1)) st_r <= S_DIV;
        end
        // one-cycle start pulse to the divider
        S_DIV: st_r <= S_DWT;
        // divider done: store field, advance
        S_DWT: if (!dbusy) begin
          res_r[fld_r] <= (d == '0) ? LonW'(fa) : LonW'(res_v);
          if (fld_r == 3'd5) st_r <= S_OUT;
          else begin fld_r <= fld_r + 3'd1; st_r <= S_WAIT; end
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = st_r == S_OUT;
  assign out_status    = stat_r;
  assign out_stamp_out = t_r;
  logic ok;
  assign ok = stat_r == ST_OK;
  assign out_lat_out   = ok ? LatW'(res_r[0]) : '0;
  assign out_lon_out   = ok ? res_r[1] : '0;
  assign out_alt_out   = ok ? MmW'(res_r[2]) : '0;
  assign out_east_out  = ok ? MmW'(res_r[3]) : '0;
  assign out_north_out = ok ? MmW'(res_r[4]) : '0;
  assign out_up_out    = ok ? MmW'(res_r[5]) : '0;
endmodule
`default_nettype wire

// ----- rtl/ssti_checker.sv -----
`default_nettype none
module ssti_checker
  import ssti_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_opcode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic signed [MmW-1:0] out_alt_out
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)) else $error("out hold");
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_PUSH |=> !out_valid) else $error("push result");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_alt_out == '0) else $error("nonzero");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("overlap");
endmodule
bind sensor_sample_time_interpolator_unit ssti_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .out_valid, .out_ready,
  .out_status, .out_alt_out
);
`default_nettype wire

// ----- verif/sensor_sample_time_interpolator_unit_checker.sv -----
`timescale 1ns / 1ps
module sensor_sample_time_interpolator_unit_checker
  import ssti_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_opcode,
  input  logic [TimeW-1:0]       in_stamp,
  input  logic signed [LatW-1:0] in_lat_in,
  input  logic signed [LonW-1:0] in_lon_in,
  input  logic signed [MmW-1:0]  in_alt_in,
  input  logic signed [MmW-1:0]  in_east_in,
  input  logic signed [MmW-1:0]  in_north_in,
  input  logic signed [MmW-1:0]  in_up_in,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [TimeW-1:0]       cfg_max_gap,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             out_status,
  input  logic [TimeW-1:0]       out_stamp_out,
  input  logic signed [LatW-1:0] out_lat_out,
  input  logic signed [LonW-1:0] out_lon_out,
  input  logic signed [MmW-1:0]  out_alt_out,
  input  logic signed [MmW-1:0]  out_east_out,
  input  logic signed [MmW-1:0]  out_north_out,
  input  logic signed [MmW-1:0]  out_up_out,
  output int                     fail_count,
  output int                     fixes_pending
);

  typedef struct {
    logic [TimeW-1:0] t;
    longint           pos [6];
  } sample_t;

  typedef struct {
    logic [1:0]       status;
    logic [TimeW-1:0] t;
    longint           pos [6];
  } fix_t;

  // shadow copy of the sample queue and the gap register
  sample_t          samples [QueueDepth];
  int               head;
  int               fill;
  logic [TimeW-1:0] gap_limit;
  fix_t             fix_q [$];

  assign fixes_pending = fix_q.size();

  function automatic int slot_of(int k);
    return (head + k) % QueueDepth;
  endfunction

  function automatic void drop_oldest();
    if (fill > 0) begin
      head = slot_of(1);
      fill--;
    end
  endfunction

  // fa + (fb - fa) * w / d, exact product, truncated toward zero
  function automatic longint lerp(longint fa, longint fb, logic [TimeW-1:0] w,
                                  logic [TimeW-1:0] d);
    longint       diff;
    logic [127:0] mag;
    logic [127:0] q;
    if (d == 0) return fa;
    diff = fb - fa;
    mag = (diff < 0) ? 128'(-diff) : 128'(diff);
    q = (mag * 128'(w)) / 128'(d);
    return (diff < 0) ? fa - longint'(q) : fa + longint'(q);
  endfunction

  function automatic void apply_request();
    fix_t             f;
    logic [TimeW-1:0] ta, tb;
    int               a, b;
    f.t = in_stamp;
    f.status = ST_FEW;
    for (int j = 0; j < 6; j++) f.pos[j] = 0;
    if (in_opcode == OP_PUSH) begin
      if (fill >= QueueDepth) drop_oldest();
      a = slot_of(fill);
      samples[a].t = in_stamp;
      samples[a].pos[0] = longint'(in_lat_in);
      samples[a].pos[1] = longint'(in_lon_in);
      samples[a].pos[2] = longint'(in_alt_in);
      samples[a].pos[3] = longint'(in_east_in);
      samples[a].pos[4] = longint'(in_north_in);
      samples[a].pos[5] = longint'(in_up_in);
      fill++;
      return;
    end
    // discard walk
    forever begin
      if (fill < 2) begin
        f.status = ST_FEW;
        break;
      end
      ta = samples[slot_of(0)].t;
      tb = samples[slot_of(1)].t;
      if (ta > f.t) begin
        f.status = ST_LATER;
        break;
      end
      if (tb < f.t) begin
        drop_oldest();
        continue;
      end
      if (f.t - ta > gap_limit || tb - f.t > gap_limit) begin
        drop_oldest();
        f.status = ST_GAP;
        break;
      end
      f.status = ST_OK;
      break;
    end
    if (f.status == ST_OK) begin
      a = slot_of(0);
      b = slot_of(1);
      for (int j = 0; j < 6; j++)
        f.pos[j] = lerp(samples[a].pos[j], samples[b].pos[j], f.t - samples[a].t,
                        samples[b].t - samples[a].t);
    end
    fix_q.insert(fix_q.size(), f);
  endfunction

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_fix();
    fix_t f;
    if (fix_q.size() == 0) begin
      report("unexpected fix", 128'(out_stamp_out), 0);
      return;
    end
    f = fix_q[0];
    fix_q.delete(0);
    if (out_status !== f.status) report("status", 128'(out_status), 128'(f.status));
    if (out_stamp_out !== f.t) report("stamp", 128'(out_stamp_out), 128'(f.t));
    if (out_lat_out !== LatW'(f.pos[0]))
      report("lat", 128'(out_lat_out), 128'(LatW'(f.pos[0])));
    if (out_lon_out !== LonW'(f.pos[1]))
      report("lon", 128'(out_lon_out), 128'(LonW'(f.pos[1])));
    if (out_alt_out !== MmW'(f.pos[2]))
      report("alt", 128'(out_alt_out), 128'(MmW'(f.pos[2])));
    if (out_east_out !== MmW'(f.pos[3]))
      report("east", 128'(out_east_out), 128'(MmW'(f.pos[3])));
    if (out_north_out !== MmW'(f.pos[4]))
      report("north", 128'(out_north_out), 128'(MmW'(f.pos[4])));
    if (out_up_out !== MmW'(f.pos[5]))
      report("up", 128'(out_up_out), 128'(MmW'(f.pos[5])));
  endtask

  initial fail_count = 0;

  // results are checked before the same edge's request is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      head = 0;
      fill = 0;
      gap_limit = MaxGapReset;
    end else begin
      if (out_valid && out_ready) compare_fix();
      if (cfg_valid && cfg_ready) gap_limit = cfg_max_gap;
      if (in_valid && in_ready) apply_request();
    end
  end

endmodule

// ----- verif/sensor_sample_time_interpolator_unit_tb.sv -----
`timescale 1ns / 1ps
module sensor_sample_time_interpolator_unit_tb
  import ssti_pkg::*;
();

  localparam int CycleLimit = 4000000;
  localparam int DrainCycles = 1500;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_opcode;
  logic [TimeW-1:0]       in_stamp;
  logic signed [LatW-1:0] in_lat_in;
  logic signed [LonW-1:0] in_lon_in;
  logic signed [MmW-1:0]  in_alt_in;
  logic signed [MmW-1:0]  in_east_in;
  logic signed [MmW-1:0]  in_north_in;
  logic signed [MmW-1:0]  in_up_in;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [TimeW-1:0]       cfg_max_gap;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_status;
  logic [TimeW-1:0]       out_stamp_out;
  logic signed [LatW-1:0] out_lat_out;
  logic signed [LonW-1:0] out_lon_out;
  logic signed [MmW-1:0]  out_alt_out;
  logic signed [MmW-1:0]  out_east_out;
  logic signed [MmW-1:0]  out_north_out;
  logic signed [MmW-1:0]  out_up_out;
  int                     fail_count;
  int                     fixes_pending;

  int               idle_pct;
  int               stall_pct;
  int               cycle_count;
  logic [TimeW-1:0] now_us;
  logic [TimeW-1:0] step_us;

  sensor_sample_time_interpolator_unit dut (.*);

  sensor_sample_time_interpolator_unit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sensor_sample_time_interpolator_unit verification failed");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(logic op, logic [TimeW-1:0] t, logic [LatW-1:0] lat,
                      logic [LonW-1:0] lon, logic [MmW-1:0] alt, logic [MmW-1:0] e,
                      logic [MmW-1:0] n, logic [MmW-1:0] u);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_opcode = op;
    in_stamp = t;
    in_lat_in = lat;
    in_lon_in = lon;
    in_alt_in = alt;
    in_east_in = e;
    in_north_in = n;
    in_up_in = u;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic push_rand(logic [TimeW-1:0] t);
    logic [63:0] r1, r2;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    if ($urandom_range(3) == 0)
      send(OP_PUSH, t, LatW'($signed(12'($urandom))), LonW'($signed(12'($urandom))),
           MmW'($signed(8'($urandom))), $urandom_range(3), $urandom, $urandom);
    else
      send(OP_PUSH, t, r1[LatW-1:0], r2[LonW-1:0], $urandom, $urandom, $urandom,
           $urandom);
  endtask

  task automatic sync_at(logic [TimeW-1:0] t);
    send(OP_SYNC, t, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // let the block go idle, then write the gap register
  task automatic set_gap(logic [TimeW-1:0] g);
    in_valid = 1'b0;
    while (fixes_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_max_gap = g;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly in-order pushes and requests around recent samples, some noise
  task automatic random_phase(int count, logic [TimeW-1:0] step_max);
    int k;
    now_us = {8'($urandom_range(254)), 32'($urandom)};
    for (k = 0; k < count; k++) begin
      step_us = $urandom_range(1, step_max);
      case ($urandom_range(19))
        0: push_rand({$urandom, $urandom});
        1: sync_at({$urandom, $urandom});
        2: push_rand(now_us);
        3: push_rand(now_us - $urandom_range(step_max));
        4, 5, 6, 7, 8, 9, 10: begin
          now_us = now_us + step_us;
          push_rand(now_us);
        end
        11: sync_at(now_us);
        12: sync_at(now_us + $urandom_range(step_max));
        default: sync_at(now_us - $urandom_range(4 * step_max));
      endcase
    end
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_PUSH;
    in_stamp = '0;
    in_lat_in = '0;
    in_lon_in = '0;
    in_alt_in = '0;
    in_east_in = '0;
    in_north_in = '0;
    in_up_in = '0;
    cfg_valid = 1'b0;
    cfg_max_gap = '0;
    out_ready = 1'b1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty queue, equal times, later front, discard, gap, overflow
    sync_at(100);
    send(OP_PUSH, 1000, {1'b0, {37{1'b1}}}, {1'b0, {38{1'b1}}}, 32'h7fffffff,
         32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    sync_at(1000);
    send(OP_PUSH, 1000, {1'b1, {37{1'b0}}}, {1'b1, {38{1'b0}}}, 32'h80000000,
         32'h80000000, 32'h80000000, 32'h80000000);
    sync_at(1000);
    send(OP_PUSH, 201000, {1'b0, {37{1'b1}}}, {1'b0, {38{1'b1}}}, 32'h7fffffff,
         32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    sync_at(500);
    sync_at(133333);
    send(OP_PUSH, 501000, 0, 0, 0, 0, 0, 0);
    sync_at(450000);
    for (int k = 0; k < 16; k++) push_rand(600000 + k * 1000);
    sync_at(614500);
    sync_at('1);

    set_gap('1);
    random_phase(250, 40'hff_ffff_ffff >> 10);
    set_gap('0);
    random_phase(150, 4);
    set_gap(MaxGapReset);
    idle_pct = 84;
    random_phase(250, 150000);
    idle_pct = 0;
    stall_pct = 84;
    set_gap(40'd5000000);
    random_phase(250, 3000000);
    idle_pct = 18;
    stall_pct = 18;
    set_gap(40'd1000);
    random_phase(250, 800);

    in_valid = 1'b0;
    while (fixes_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0)
      $display("sensor_sample_time_interpolator_unit verification clean");
    else
      $display("sensor_sample_time_interpolator_unit verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ssti_pkg.sv
rtl/ssti_ram.sv
rtl/ssti_div.sv
rtl/sensor_sample_time_interpolator_unit.sv
rtl/ssti_checker.sv
verif/sensor_sample_time_interpolator_unit_checker.sv
verif/sensor_sample_time_interpolator_unit_tb.sv
